/* hw/rtl/uvn_pkg.sv */
// uvn_pkg: shared constants and types for the 2d unit vector normalizer
// no dependencies; imported by every module under hw/rtl

package uvn_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH     = 16;

  // per-item sign and zero flags that ride along the pipeline
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic nonzero;
  } uvn_flags_t;

endpackage

/* hw/rtl/unit_vector_normalize_2d.sv */
// unit_vector_normalize_2d: top level, prep stages, bit cell chain, output register
// depends on uvn_pkg, uvn_prep, uvn_cell
//
//  channel | direction | tdata (low bit up)          | tuser
//  s_*     | in        | x_component, y_component    | -
//  m_*     | out       | unit_x, unit_y (Q2.14)      | success
//
// one transfer per cycle in and out when m_tready stays high
// pipeline: three prep stages, one cell per result bit, output register
// each cell holds one item and passes it on as soon as its neighbor has room
// rst clears all valid bits; data registers are not reset
// m_tready low stalls only the stages that hold items, bubbles still fill

module unit_vector_normalize_2d import uvn_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((2*IN_WIDTH+7)/8)*8-1:0]   s_tdata,  // x_component, y_component
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*OUT_WIDTH-1:0]            m_tdata,  // unit_x, unit_y
  output logic [0:0]                        m_tuser   // success
);

  localparam int W  = IN_WIDTH;
  localparam int SW = 2 * IN_WIDTH;
  localparam int RW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;
  localparam int QW = FRAC_BITS + 1;
  localparam int NC = FRAC_BITS + 1;
  localparam int EW = (QW > OUT_WIDTH) ? QW : OUT_WIDTH;

  logic                 cv     [0:NC];
  logic                 cr     [0:NC];
  uvn_flags_t           cflags [0:NC];
  logic        [SW-1:0] cs     [0:NC];
  logic signed [RW-1:0] crx    [0:NC];
  logic signed [RW-1:0] cry    [0:NC];
  logic signed [RW-1:0] cpx    [0:NC];
  logic signed [RW-1:0] cpy    [0:NC];
  logic        [QW-1:0] cqx    [0:NC];
  logic        [QW-1:0] cqy    [0:NC];

  logic                 out_en;
  logic        [EW-1:0] qx_ext, qy_ext;
  logic        [EW-1:0] ux_full, uy_full;
  uvn_flags_t           last_flags;

  uvn_prep #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      ($signed(s_tdata[W-1:0])),
    .in_y      ($signed(s_tdata[2*W-1:W])),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_flags (cflags[0]),
    .out_s     (cs[0]),
    .out_rx    (crx[0]),
    .out_ry    (cry[0]),
    .out_px    (cpx[0]),
    .out_py    (cpy[0])
  );

  assign cqx[0] = '0;
  assign cqy[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    uvn_cell #(
      .IN_WIDTH  (IN_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .BIT       (FRAC_BITS - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .in_flags  (cflags[i]),
      .in_s      (cs[i]),
      .in_rx     (crx[i]),
      .in_ry     (cry[i]),
      .in_px     (cpx[i]),
      .in_py     (cpy[i]),
      .in_qx     (cqx[i]),
      .in_qy     (cqy[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .out_flags (cflags[i+1]),
      .out_s     (cs[i+1]),
      .out_rx    (crx[i+1]),
      .out_ry    (cry[i+1]),
      .out_px    (cpx[i+1]),
      .out_py    (cpy[i+1]),
      .out_qx    (cqx[i+1]),
      .out_qy    (cqy[i+1])
    );
  end

  assign out_en = !m_tvalid || m_tready;
  assign cr[NC] = out_en;

  assign last_flags = cflags[NC];
  assign qx_ext  = EW'(cqx[NC]);
  assign qy_ext  = EW'(cqy[NC]);
  assign ux_full = last_flags.neg_x ? (~qx_ext + 1'b1) : qx_ext;
  assign uy_full = last_flags.neg_y ? (~qy_ext + 1'b1) : qy_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_en) begin
      m_tvalid <= cv[NC];
    end
  end

  // zero vector gives zero components
  always_ff @(posedge clk) begin
    if (out_en) begin
      m_tdata[OUT_WIDTH-1:0]           <= last_flags.nonzero ? ux_full[OUT_WIDTH-1:0] : '0;
      m_tdata[2*OUT_WIDTH-1:OUT_WIDTH] <= last_flags.nonzero ? uy_full[OUT_WIDTH-1:0] : '0;
      m_tuser[0]                       <= last_flags.nonzero;
    end
  end

endmodule

/* hw/rtl/uvn_prep.sv */
// uvn_prep: magnitudes, squares and initial remainders for the rounding chain
// depends on uvn_pkg

module uvn_prep import uvn_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [IN_WIDTH-1:0]                   in_x,
  input  logic signed [IN_WIDTH-1:0]                   in_y,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output uvn_flags_t                                   out_flags,
  output logic        [2*IN_WIDTH-1:0]                 out_s,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]     out_rx,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]     out_ry,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]     out_px,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]     out_py
);

  localparam int W  = IN_WIDTH;
  localparam int SW = 2 * IN_WIDTH;
  localparam int RW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;

  logic          va, vb, vc;
  logic          en_a, en_b, en_c;
  logic [W-1:0]  xu, yu;
  logic [W-1:0]  mag_x, mag_y;
  logic          neg_xa, neg_ya, neg_xb, neg_yb;
  logic [SW-1:0] sq_x, sq_y;
  logic [SW-1:0] prod_x, prod_y;
  logic [SW-1:0] sum_s;

  assign en_c     = !vc || out_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;
  assign out_valid = vc;

  assign xu = in_x;
  assign yu = in_y;

  assign prod_x = mag_x * mag_x;
  assign prod_y = mag_y * mag_y;
  assign sum_s  = sq_x + sq_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
    end
  end

  // stage a: magnitudes, most negative value maps to 2^(W-1) exactly
  always_ff @(posedge clk) begin
    if (en_a) begin
      neg_xa <= xu[W-1];
      neg_ya <= yu[W-1];
      mag_x  <= xu[W-1] ? (~xu + 1'b1) : xu;
      mag_y  <= yu[W-1] ? (~yu + 1'b1) : yu;
    end
  end

  // stage b: squares
  always_ff @(posedge clk) begin
    if (en_b) begin
      neg_xb <= neg_xa;
      neg_yb <= neg_ya;
      sq_x   <= prod_x;
      sq_y   <= prod_y;
    end
  end

  // stage c: remainder a^2*2^(2F+2) - s and partial product -s for q = 0
  always_ff @(posedge clk) begin
    if (en_c) begin
      out_flags.neg_x   <= neg_xb;
      out_flags.neg_y   <= neg_yb;
      out_flags.nonzero <= (sum_s != '0);
      out_s             <= sum_s;
      out_rx <= $signed(RW'(sq_x) << (2 * FRAC_BITS + 2)) - $signed(RW'(sum_s));
      out_ry <= $signed(RW'(sq_y) << (2 * FRAC_BITS + 2)) - $signed(RW'(sum_s));
      out_px <= -$signed(RW'(sum_s));
      out_py <= -$signed(RW'(sum_s));
    end
  end

endmodule

/* hw/rtl/uvn_cell.sv */
// uvn_cell: one result bit of the rounded quotient for both components
// depends on uvn_pkg; chained by the top level, one cell per bit

module uvn_cell import uvn_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  uvn_flags_t                               in_flags,
  input  logic        [2*IN_WIDTH-1:0]             in_s,
  input  logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] in_rx,
  input  logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] in_ry,
  input  logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] in_px,
  input  logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] in_py,
  input  logic        [FRAC_BITS:0]                in_qx,
  input  logic        [FRAC_BITS:0]                in_qy,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output uvn_flags_t                               out_flags,
  output logic        [2*IN_WIDTH-1:0]             out_s,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] out_rx,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] out_ry,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] out_px,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0] out_py,
  output logic        [FRAC_BITS:0]                out_qx,
  output logic        [FRAC_BITS:0]                out_qy
);

  localparam int RW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;
  localparam int QW = FRAC_BITS + 1;
  localparam bit TOP_BIT = (BIT == FRAC_BITS);

  logic                 v;
  logic                 en;
  logic signed [RW-1:0] s_ext;
  logic signed [RW-1:0] trial_x, trial_y;
  logic                 acc_x, acc_y;

  assign en        = !v || out_ready;
  assign in_ready  = en;
  assign out_valid = v;

  assign s_ext = $signed(RW'(in_s));

  // trial q+2^b accepted when (2q+2^(b+1)-1)^2 * s still fits under a^2*2^(2F+2)
  assign trial_x = in_rx - (in_px <<< (BIT + 2)) - (s_ext <<< (2 * BIT + 2));
  assign trial_y = in_ry - (in_py <<< (BIT + 2)) - (s_ext <<< (2 * BIT + 2));

  // once q reaches 2^F no lower bit may be added
  assign acc_x = (TOP_BIT || !in_qx[FRAC_BITS]) && !trial_x[RW-1];
  assign acc_y = (TOP_BIT || !in_qy[FRAC_BITS]) && !trial_y[RW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_flags <= in_flags;
      out_s     <= in_s;
      out_rx    <= acc_x ? trial_x : in_rx;
      out_ry    <= acc_y ? trial_y : in_ry;
      out_px    <= acc_x ? (in_px + (s_ext <<< (BIT + 1))) : in_px;
      out_py    <= acc_y ? (in_py + (s_ext <<< (BIT + 1))) : in_py;
      out_qx    <= in_qx | (QW'(acc_x) << BIT);
      out_qy    <= in_qy | (QW'(acc_y) << BIT);
    end
  end

endmodule

/* hw/rtl/uvn_checker.sv */
// uvn_checker: port-level assertions for unit_vector_normalize_2d, bound to the top level
// depends on uvn_pkg

module uvn_checker import uvn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [2*OUT_WIDTH-1:0] m_tdata,
  input logic [0:0]             m_tuser
);

  localparam int LIM = 1 << FRAC_BITS;

  // stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a draining output never back-pressures the input
  assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // zero vector gives zero components
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero components for zero vector");

  // components stay within one unit
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (FRAC_BITS > OUT_WIDTH - 2) ||
      ($signed(m_tdata[OUT_WIDTH-1:0]) <= LIM &&
       $signed(m_tdata[OUT_WIDTH-1:0]) >= -LIM &&
       $signed(m_tdata[2*OUT_WIDTH-1:OUT_WIDTH]) <= LIM &&
       $signed(m_tdata[2*OUT_WIDTH-1:OUT_WIDTH]) >= -LIM))
    else $error("component beyond unit range");

  // nothing offered right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind unit_vector_normalize_2d uvn_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_uvn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
